### rtl/integer_literal_range_check_core_macros.svh
// Assertion macros shared by the integer literal range check RTL.
`ifndef INTEGER_LITERAL_RANGE_CHECK_CORE_MACROS_SVH
`define INTEGER_LITERAL_RANGE_CHECK_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ILRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ilrc_pkg.sv
// Types, constants and helper functions for the integer literal range check.
package ilrc_pkg;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BIN = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        OUTCOME_DONE     = 2'd0,
        OUTCOME_OVERFLOW = 2'd1,
        OUTCOME_STOPPED  = 2'd2
    } outcome_t;

    localparam int          ACC_W          = 64;
    localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0]  CHAR_ZERO       = 8'h30;
    localparam logic [7:0]  CHAR_NINE       = 8'h39;
    localparam logic [7:0]  CHAR_LC_A       = 8'h61;
    localparam logic [7:0]  CHAR_LC_F       = 8'h66;
    localparam logic [7:0]  CHAR_UC_A       = 8'h41;
    localparam logic [7:0]  CHAR_UC_F       = 8'h46;
    localparam logic [7:0]  CHAR_LC_X       = 8'h78;
    localparam logic [7:0]  CHAR_UC_X       = 8'h58;
    localparam logic [7:0]  CHAR_LC_O       = 8'h6F;
    localparam logic [7:0]  CHAR_UC_O       = 8'h4F;
    localparam logic [7:0]  CHAR_LC_B       = 8'h62;
    localparam logic [7:0]  CHAR_UC_B       = 8'h42;

    // bound / base for bound 2^63 and 2^63-1
    localparam logic [ACC_W-1:0] QUOT_DEC = 64'd922337203685477580;
    localparam logic [ACC_W-1:0] QUOT_HEX = 64'h0800_0000_0000_0000;
    localparam logic [ACC_W-1:0] QUOT_OCT = 64'h1000_0000_0000_0000;
    localparam logic [ACC_W-1:0] QUOT_BIN = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        radix_t           radix;
        logic [1:0]       pos;
        logic             first_zero;
        logic             stopped;
        logic             ovf;
        logic             bound;
        logic             open;
    } ilrc_state_t;

    localparam ilrc_state_t STATE_CLEAR = '{
        acc:        '0,
        radix:      RADIX_DEC,
        pos:        2'd0,
        first_zero: 1'b0,
        stopped:    1'b0,
        ovf:        1'b0,
        bound:      1'b1,
        open:       1'b0
    };

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    function automatic digit_t digit_value(input logic [7:0] c);
        digit_t d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d.val = 4'(c - CHAR_ZERO);
        end
        else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            d.val = 4'(c - CHAR_LC_A + 8'd10);
        end
        else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            d.val = 4'(c - CHAR_UC_A + 8'd10);
        end
        else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    // RADIX_DEC means no prefix letter
    function automatic radix_t prefix_radix(input logic [7:0] c);
        radix_t r;
        r = RADIX_DEC;
        if (c == CHAR_LC_X || c == CHAR_UC_X) begin
            r = RADIX_HEX;
        end
        else if (c == CHAR_LC_O || c == CHAR_UC_O) begin
            r = RADIX_OCT;
        end
        else if (c == CHAR_LC_B || c == CHAR_UC_B) begin
            r = RADIX_BIN;
        end
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] radix_quot(input radix_t r, input logic bound);
        logic [ACC_W-1:0] q;
        case (r)
            RADIX_DEC: q = QUOT_DEC;
            RADIX_HEX: q = bound ? QUOT_HEX : QUOT_HEX - 64'd1;
            RADIX_OCT: q = bound ? QUOT_OCT : QUOT_OCT - 64'd1;
            default:   q = bound ? QUOT_BIN : QUOT_BIN - 64'd1;
        endcase
        return q;
    endfunction

    function automatic logic [3:0] radix_rem(input radix_t r, input logic bound);
        logic [3:0] m;
        case (r)
            RADIX_DEC: m = bound ? 4'd8 : 4'd7;
            RADIX_HEX: m = bound ? 4'd0 : 4'd15;
            RADIX_OCT: m = bound ? 4'd0 : 4'd7;
            default:   m = bound ? 4'd0 : 4'd1;
        endcase
        return m;
    endfunction

    function automatic logic [ACC_W-1:0] scale_by_radix(input logic [ACC_W-1:0] a,
                                                        input radix_t r);
        logic [ACC_W-1:0] s;
        case (r)
            RADIX_DEC: s = (a << 3) + (a << 1);
            RADIX_HEX: s = a << 4;
            RADIX_OCT: s = a << 3;
            default:   s = a << 1;
        endcase
        return s;
    endfunction

endpackage

### rtl/ilrc_if.sv
// Valid/ready channel interfaces for literal characters and range results.
interface ilrc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       char_present;
    logic       last;
    logic       allow_max_magnitude;

    modport source (output valid, output character, output char_present, output last,
                    output allow_max_magnitude, input ready);
    modport sink   (input valid, input character, input char_present, input last,
                    input allow_max_magnitude, output ready);
endinterface

interface ilrc_result_if;
    logic       valid;
    logic       ready;
    logic       fits;
    logic [1:0] outcome;

    modport source (output valid, output fits, output outcome, input ready);
    modport sink   (input valid, input fits, input outcome, output ready);
endinterface

### rtl/ilrc_step.sv
// Next-state logic for one literal character: prefix, digit decode, overflow test.
module ilrc_step
    import ilrc_pkg::*;
(
    input  ilrc_state_t cur,
    input  logic [7:0]  character,
    input  logic        char_present,
    input  logic        allow_max_magnitude,
    output ilrc_state_t nxt
);

    digit_t           dig;
    radix_t           pfx;
    logic [ACC_W-1:0] quot;
    logic [3:0]       rem;
    logic             bound;

    always_comb
    begin
        nxt   = cur;
        bound = cur.open ? cur.bound : allow_max_magnitude;
        nxt.bound = bound;
        nxt.open  = 1'b1;
        dig   = digit_value(character);
        pfx   = prefix_radix(character);
        quot  = radix_quot(cur.radix, bound);
        rem   = radix_rem(cur.radix, bound);

        if (char_present && character != CHAR_UNDERSCORE && !cur.stopped && !cur.ovf)
        begin
            if (cur.pos == 2'd1 && cur.first_zero && pfx != RADIX_DEC)
            begin
                nxt.radix = pfx;
                nxt.pos   = 2'd2;
            end
            else
            begin
                if (cur.pos == 2'd0)
                begin
                    nxt.first_zero = (character == CHAR_ZERO);
                end
                if (cur.pos != 2'd2)
                begin
                    nxt.pos = cur.pos + 2'd1;
                end
                if (!dig.ok)
                begin
                    nxt.stopped = 1'b1;
                end
                else if (cur.acc > quot || (cur.acc == quot && dig.val > rem))
                begin
                    nxt.ovf = 1'b1;
                end
                else
                begin
                    nxt.acc = scale_by_radix(cur.acc, cur.radix) + {60'd0, dig.val};
                end
            end
        end
    end

endmodule

### rtl/integer_literal_range_check_core.sv
// Integer literal range check: one character item per clock; the result for a
// literal appears in the output register in the cycle after its last item is taken.
// A new item is accepted every cycle while the output register is empty or being
// drained; the only stall is a held result that the sink has not taken.
// The per-character work is a digit decode, a 64-bit compare against the
// per-radix quotient and a shift-and-add by the base, all in combinational logic.
`include "integer_literal_range_check_core_macros.svh"

module integer_literal_range_check_core
    import ilrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ilrc_char_if.sink     chars,
    ilrc_result_if.source result
);

    ilrc_state_t state_reg;
    ilrc_state_t state_next;
    logic        out_valid_reg;
    logic        fits_reg;
    outcome_t    outcome_reg;
    logic        accept;

    ilrc_step u_step (
        .cur                 (state_reg),
        .character           (chars.character),
        .char_present        (chars.char_present),
        .allow_max_magnitude (chars.allow_max_magnitude),
        .nxt                 (state_next)
    );

    assign chars.ready    = !out_valid_reg || result.ready;
    assign accept         = chars.valid && chars.ready;
    assign result.valid   = out_valid_reg;
    assign result.fits    = fits_reg;
    assign result.outcome = outcome_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= chars.last ? STATE_CLEAR : state_next;
            end
            if (accept && chars.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && chars.last)
        begin
            fits_reg    <= !state_next.ovf;
            outcome_reg <= state_next.ovf     ? OUTCOME_OVERFLOW :
                           state_next.stopped ? OUTCOME_STOPPED  : OUTCOME_DONE;
        end
    end

    `ILRC_ASSERT_NOW(a_ovf_stop_excl, clk, rst_n, 1'b1, !(state_reg.ovf && state_reg.stopped),
        "overflow and early stop both set")
    `ILRC_ASSERT_NOW(a_prefix_ctx, clk, rst_n, state_reg.radix != RADIX_DEC,
        state_reg.first_zero && state_reg.pos == 2'd2, "radix prefix without leading zero")
    `ILRC_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && chars.last,
        out_valid_reg && !state_reg.open && state_reg.acc == '0, "last item did not close literal")
    `ILRC_ASSERT_NOW(a_fits_code, clk, rst_n, out_valid_reg,
        fits_reg == (outcome_reg != OUTCOME_OVERFLOW), "fits disagrees with outcome")

endmodule

### tb/literal_range_checker.sv
`timescale 1ns / 100ps
// Scoreboard that predicts each literal's range verdict and checks the result channel.
module literal_range_checker
    import ilrc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ilrc_char_if   chars,
    ilrc_result_if result,
    output int     mismatches,
    output int     outstanding
);

    typedef struct packed {
        logic     fits;
        outcome_t outcome;
    } verdict_t;

    verdict_t    verdict_q[$];
    verdict_t    oldest;
    logic [63:0] value_acc;
    radix_t      radix_sel;
    logic [1:0]  char_count;
    logic        lead_zero;
    logic        halted;
    logic        too_big;
    logic        wide_bound;
    logic        in_literal;
    int          errs;
    int          took_last;
    int          took_result;

    function automatic void restart_literal();
        value_acc  = '0;
        radix_sel  = RADIX_DEC;
        char_count = 2'd0;
        lead_zero  = 1'b0;
        halted     = 1'b0;
        too_big    = 1'b0;
        wide_bound = 1'b1;
        in_literal = 1'b0;
    endfunction

    function automatic void append_verdict(input verdict_t v);
        verdict_q.insert(verdict_q.size(), v);
    endfunction

    function automatic int char_digit(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            return int'(c - CHAR_ZERO);
        end
        if (c >= CHAR_LC_A && c <= CHAR_LC_F)
        begin
            return int'(c - CHAR_LC_A) + 10;
        end
        if (c >= CHAR_UC_A && c <= CHAR_UC_F)
        begin
            return int'(c - CHAR_UC_A) + 10;
        end
        return -1;
    endfunction

    function automatic radix_t letter_radix(input logic [7:0] c);
        if (c == CHAR_LC_X || c == CHAR_UC_X)
        begin
            return RADIX_HEX;
        end
        if (c == CHAR_LC_O || c == CHAR_UC_O)
        begin
            return RADIX_OCT;
        end
        if (c == CHAR_LC_B || c == CHAR_UC_B)
        begin
            return RADIX_BIN;
        end
        return RADIX_DEC;
    endfunction

    function automatic void absorb_character(input logic [7:0] c);
        radix_t      pr;
        int          d;
        logic [63:0] ceiling;
        logic [63:0] b;
        logic [63:0] q;
        logic [63:0] r;
        if (c == CHAR_UNDERSCORE || halted || too_big)
        begin
            return;
        end
        pr = letter_radix(c);
        if (char_count == 2'd1 && lead_zero && pr != RADIX_DEC)
        begin
            radix_sel  = pr;
            char_count = 2'd2;
            return;
        end
        if (char_count == 2'd0)
        begin
            lead_zero = (c == CHAR_ZERO);
        end
        if (char_count < 2'd2)
        begin
            char_count = char_count + 2'd1;
        end
        d = char_digit(c);
        if (d < 0)
        begin
            halted = 1'b1;
            return;
        end
        ceiling = wide_bound ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        case (radix_sel)
            RADIX_HEX: b = 64'd16;
            RADIX_OCT: b = 64'd8;
            RADIX_BIN: b = 64'd2;
            default:   b = 64'd10;
        endcase
        q = ceiling / b;
        r = ceiling % b;
        if (value_acc > q || (value_acc == q && 64'(d) > r))
        begin
            too_big = 1'b1;
        end
        else
        begin
            value_acc = value_acc * b + 64'(d);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_literal();
            verdict_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs        = 0;
            took_last   = 0;
            took_result = 0;
            // results first: a result never belongs to an item taken on the same edge
            if (result.valid && result.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result fits=%0b outcome=%0d", $time,
                             result.fits, result.outcome);
                    errs++;
                end
                else
                begin
                    oldest      = verdict_q.pop_front();
                    took_result = 1;
                    if (result.fits !== oldest.fits)
                    begin
                        $display("%0t: fits mismatch expected %0b actual %0b", $time,
                                 oldest.fits, result.fits);
                        errs++;
                    end
                    if (result.outcome !== oldest.outcome)
                    begin
                        $display("%0t: outcome mismatch expected %0d actual %0d", $time,
                                 oldest.outcome, result.outcome);
                        errs++;
                    end
                end
            end
            if (chars.valid && chars.ready)
            begin
                if (!in_literal)
                begin
                    wide_bound = chars.allow_max_magnitude;
                    in_literal = 1'b1;
                end
                if (chars.char_present)
                begin
                    absorb_character(chars.character);
                end
                if (chars.last)
                begin
                    append_verdict('{
                        fits:    !too_big,
                        outcome: too_big ? OUTCOME_OVERFLOW
                                         : (halted ? OUTCOME_STOPPED : OUTCOME_DONE)
                    });
                    restart_literal();
                    took_last = 1;
                end
            end
            mismatches  <= mismatches + errs;
            outstanding <= outstanding + took_last - took_result;
        end
    end

endmodule

### tb/tb_integer_literal_range_check_core.sv
`timescale 1ns / 100ps
// Testbench top: drives literal characters, paces the result side and reports the verdict.
module tb_integer_literal_range_check_core;
    import ilrc_pkg::*;

    localparam int ITEM_TARGET = 900;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 150;
    localparam logic [7:0] PREFIX_LETTERS [6] = '{
        CHAR_LC_X, CHAR_UC_X, CHAR_LC_O, CHAR_UC_O, CHAR_LC_B, CHAR_UC_B
    };

    typedef struct packed {
        logic       present;
        logic [7:0] ch;
    } lit_entry_t;

    logic       clk;
    logic       rst_n;
    int         mismatches;
    int         outstanding;
    int         cycles = 0;
    int         items_sent = 0;
    lit_entry_t lit_text[$];

    ilrc_char_if   chars_if();
    ilrc_result_if result_if();

    integer_literal_range_check_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (result_if)
    );

    literal_range_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars_if),
        .result      (result_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic append_entry(input logic present_bit, input logic [7:0] byte_val);
        lit_entry_t e;
        e.present = present_bit;
        e.ch      = byte_val;
        lit_text.insert(lit_text.size(), e);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            append_entry(1'b1, s[i]);
        end
    endtask

    // first item carries the bound; later items get a random, ignored bound bit
    task automatic send_literal(input logic bound, input bit eager);
        int gap;
        if (lit_text.size() == 0)
        begin
            append_entry(1'b0, 8'($urandom));
        end
        foreach (lit_text[k])
        begin
            gap = eager ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                chars_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            chars_if.valid               <= 1'b1;
            chars_if.character           <= lit_text[k].ch;
            chars_if.char_present        <= lit_text[k].present;
            chars_if.last                <= (k == lit_text.size() - 1);
            chars_if.allow_max_magnitude <= (k == 0) ? bound : 1'($urandom);
            @(posedge clk);
            while (!chars_if.ready) @(posedge clk);
            items_sent++;
        end
        lit_text.delete();
    endtask

    initial
    begin
        int         gap;
        int         taken;
        bit         eager;
        result_if.ready <= 1'b0;
        taken = 0;
        eager = 1'b0;
        @(posedge clk);
        forever
        begin
            if (taken % 12 == 0)
            begin
                eager = ($urandom_range(0, 2) == 0);
            end
            gap = eager ? 0 : $urandom_range(0, 11);
            if (taken == 8 || taken == 50)
            begin
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid) @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        radix_t      base_sel;
        logic [63:0] num;
        logic [7:0]  digits[$];
        logic [7:0]  ch;
        int          radix_n;
        int          lits;
        bit          upper;
        bit          eager;
        rst_n                        <= 1'b0;
        chars_if.valid               <= 1'b0;
        chars_if.character           <= 8'h00;
        chars_if.char_present        <= 1'b0;
        chars_if.last                <= 1'b0;
        chars_if.allow_max_magnitude <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty literal
        send_literal(1'b1, 1'b0);
        // prefix without digits
        put_text("0X");
        send_literal(1'b0, 1'b0);
        // stop at a non-digit, rest ignored
        put_text("7g9");
        send_literal(1'b1, 1'b1);
        // underscore and a missing character inside a binary literal
        put_text("0b1");
        append_entry(1'b0, 8'hA5);
        put_text("_0");
        send_literal(1'b0, 1'b0);
        // digits above the base
        put_text("0o9F");
        send_literal(1'b1, 1'b0);
        put_text("__");
        send_literal(1'b0, 1'b1);
        append_entry(1'b1, 8'hFF);
        append_entry(1'b1, 8'h00);
        send_literal(1'b1, 1'b0);

        lits = 0;
        while (items_sent < ITEM_TARGET)
        begin
            eager = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 6)
            begin
                // well-formed number close to the bounds, close to the top of 64 bits, or of random size
                case ($urandom_range(0, 7))
                    0, 1, 2: base_sel = RADIX_DEC;
                    3, 4:    base_sel = RADIX_HEX;
                    5, 6:    base_sel = RADIX_OCT;
                    default: base_sel = RADIX_BIN;
                endcase
                case (base_sel)
                    RADIX_HEX: radix_n = 16;
                    RADIX_OCT: radix_n = 8;
                    RADIX_BIN: radix_n = 2;
                    default:   radix_n = 10;
                endcase
                case ($urandom_range(0, 3))
                    0, 1:    num = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 6)) - 64'd3;
                    2:       num = {$urandom, $urandom} >> $urandom_range(0, 63);
                    default: num = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
                endcase
                digits.delete();
                do
                begin
                    digits.push_front(8'(num % 64'(radix_n)));
                    num = num / 64'(radix_n);
                end
                while (num != 0);
                if ($urandom_range(0, 5) == 0)
                begin
                    digits.insert(digits.size(), 8'($urandom_range(0, radix_n - 1)));
                end
                upper = 1'($urandom);
                if (base_sel == RADIX_DEC)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        put_text("0");
                    end
                end
                else
                begin
                    put_text("0");
                    append_entry(1'b1,
                        PREFIX_LETTERS[2 * (int'(base_sel) - 1) + int'(upper)]);
                end
                foreach (digits[j])
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        put_text("_");
                    end
                    if ($urandom_range(0, 29) == 0)
                    begin
                        append_entry(1'b0, 8'($urandom));
                    end
                    if (digits[j] < 8'd10)
                    begin
                        ch = CHAR_ZERO + digits[j];
                    end
                    else
                    begin
                        ch = ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + digits[j] - 8'd10;
                    end
                    append_entry(1'b1, ch);
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    append_entry(1'b1, 8'($urandom));
                end
            end
            else
            begin
                // short free-form text: prefixes, stray letters, arbitrary bytes
                repeat ($urandom_range(0, 8))
                begin
                    case ($urandom_range(0, 5))
                        0:       ch = 8'($urandom);
                        1:       ch = CHAR_ZERO;
                        2:       ch = CHAR_ZERO + 8'($urandom_range(0, 9));
                        3:       ch = ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A)
                                      + 8'($urandom_range(0, 5));
                        4:       ch = PREFIX_LETTERS[$urandom_range(0, 5)];
                        default: ch = CHAR_UNDERSCORE;
                    endcase
                    append_entry(($urandom_range(0, 11) != 0), ch);
                end
            end
            send_literal(1'($urandom), eager);
            lits++;
            if (lits == 15 || lits == 45)
            begin
                chars_if.valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0) @(posedge clk);
            end
        end

        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ilrc_pkg.sv
rtl/ilrc_if.sv
rtl/ilrc_step.sv
rtl/integer_literal_range_check_core.sv
tb/literal_range_checker.sv
tb/tb_integer_literal_range_check_core.sv
